// ===== src/isc_pkg.sv =====
package isc_pkg;

  localparam int MaxSubs   = 1024;
  localparam int MaxLevels = 8;
  localparam int AttrW     = 6;
  localparam int ValueBits = 16;
  localparam int SubW      = $clog2(MaxSubs);
  localparam int TotW      = SubW + 1;
  localparam int LvlW      = $clog2(MaxLevels);
  localparam int LvlCntW   = LvlW + 1;
  localparam int PairCntW  = 4;
  localparam int FuncW     = 3;
  localparam int StatusW   = 2;
  localparam int HandleW   = 10;

  localparam logic [FuncW-1:0] FuncAdd    = 3'd0;
  localparam logic [FuncW-1:0] FuncCommit = 3'd1;
  localparam logic [FuncW-1:0] FuncBegin  = 3'd2;
  localparam logic [FuncW-1:0] FuncPair   = 3'd3;
  localparam logic [FuncW-1:0] FuncRead   = 3'd4;

  typedef enum logic [StatusW-1:0] {
    StOk       = 2'd0,
    StFull     = 2'd1,
    StBadCount = 2'd2,
    StNoMatch  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    OpAdd, OpCommit, OpBegin, OpPair, OpRead, OpNop
  } op_e;

  typedef struct packed {
    op_e                  op;
    logic [AttrW-1:0]     attribute;
    logic [ValueBits-1:0] lov;
    logic [ValueBits-1:0] hib;
  } cmd_t;

  typedef struct packed {
    status_e              status;
    logic [HandleW-1:0]   handle;
  } res_t;

  function automatic op_e classify(logic [FuncW-1:0] func);
    op_e op;
    unique case (func)
      FuncAdd:    op = OpAdd;
      FuncCommit: op = OpCommit;
      FuncBegin:  op = OpBegin;
      FuncPair:   op = OpPair;
      FuncRead:   op = OpRead;
      default:    op = OpNop;
    endcase
    return op;
  endfunction

endpackage

// ===== src/interval_subscription_matcher.sv =====
// A begin event runs a sweep that clears the mismatch marks; event pair and read scan the
// committed subscriptions.
// Throughput: one item at a time in the back end; a two-entry queue takes new items meanwhile.
// Reset (rst_ni, async, active low): all counters zero, then a sweep clears the
// mismatch marks before the first item is carried out.
module interval_subscription_matcher import isc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  logic [FuncW-1:0]     func_i,
  input  logic [AttrW-1:0]     attribute_i,
  input  logic [ValueBits-1:0] low_or_value_i,
  input  logic [ValueBits-1:0] high_bound_i,
  output logic                 empty,
  input  logic                 pop,
  output logic [StatusW-1:0]   status_o,
  output logic [HandleW-1:0]   handle_o
);

  logic cmd_valid, cmd_pop, res_valid, res_ready;
  cmd_t cmd;
  res_t res;

  // front end: decodes and buffers items
  isc_front u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full),
    .func_i, .attribute_i, .low_or_value_i, .high_bound_i,
    .cmd_valid_o(cmd_valid), .cmd_o(cmd), .cmd_pop_i(cmd_pop)
  );

  // back end: stores, scans and answers
  isc_back u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_i(cmd), .cmd_pop_o(cmd_pop),
    .res_valid_o(res_valid), .res_o(res), .res_ready_i(res_ready)
  );

  // two-entry result queue toward the consumer
  res_t       oq_q [2];
  logic       owp_q, orp_q;
  logic [1:0] ocnt_q;
  logic       owr, ord;

  assign res_ready = (ocnt_q != 2'd2);
  assign owr       = res_valid && res_ready;
  assign empty     = (ocnt_q == 2'd0);
  assign ord       = pop && !empty;
  assign status_o  = oq_q[orp_q].status;
  assign handle_o  = oq_q[orp_q].handle;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owp_q  <= 1'b0;
      orp_q  <= 1'b0;
      ocnt_q <= 2'd0;
    end else begin
      owp_q  <= owp_q ^ owr;
      orp_q  <= orp_q ^ ord;
      ocnt_q <= ocnt_q + {1'b0, owr} - {1'b0, ord};
    end
  end

  always_ff @(posedge clk_i) begin
    if (owr) oq_q[owp_q] <= res;
  end

endmodule

// ===== src/isc_front.sv =====
module isc_front import isc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  output logic                 full_o,
  input  logic [FuncW-1:0]     func_i,
  input  logic [AttrW-1:0]     attribute_i,
  input  logic [ValueBits-1:0] low_or_value_i,
  input  logic [ValueBits-1:0] high_bound_i,
  output logic                 cmd_valid_o,
  output cmd_t                 cmd_o,
  input  logic                 cmd_pop_i
);

  // two-entry command queue, items decoded on entry
  cmd_t       mem_q [2];
  logic       wp_q, wp_d, rp_q, rp_d;
  logic [1:0] cnt_q, cnt_d;
  logic       wr, rd;

  assign full_o      = (cnt_q == 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = mem_q[rp_q];
  assign wr          = push_i && !full_o;
  assign rd          = cmd_pop_i && cmd_valid_o;

  always_comb begin
    wp_d  = wp_q ^ wr;
    rp_d  = rp_q ^ rd;
    cnt_d = cnt_q + {1'b0, wr} - {1'b0, rd};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wp_q] <= '{op: classify(func_i), attribute: attribute_i,
                       lov: low_or_value_i, hib: high_bound_i};
    end
  end

endmodule

// ===== src/isc_back.sv =====
module isc_back import isc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cmd_valid_i,
  input  cmd_t cmd_i,
  output logic cmd_pop_o,
  output logic res_valid_o,
  output res_t res_o,
  input  logic res_ready_i
);

  typedef enum logic [4:0] {
    StateIdle  = 5'b00001,
    StateClear = 5'b00010,
    StatePair  = 5'b00100,
    StateRead  = 5'b01000,
    StateDone  = 5'b10000
  } state_e;

  typedef struct packed {
    logic [AttrW-1:0]     attr;
    logic [ValueBits-1:0] lo;
    logic [ValueBits-1:0] hi;
  } row_t;

  state_e              state_q, state_d;
  logic [TotW-1:0]     total_q, total_d;
  logic [LvlCntW-1:0]  pend_q, pend_d;
  logic [PairCntW-1:0] pairs_q, pairs_d;
  logic [TotW-1:0]     cursor_q, cursor_d;
  logic [TotW-1:0]     iss_q, iss_d;
  logic                pv_q, pv_d;
  logic [SubW-1:0]     pa_q, pa_d;
  logic                reply_q, reply_d;
  cmd_t                cmd_q, cmd_d;
  res_t                res_q, res_d;

  logic                cs_we, cnt_we, mk_we;
  logic [SubW-1:0]     mk_addr;
  logic                mk_data;
  logic [SubW-1:0]     rd_addr;

  logic [LvlCntW-1:0]  count_mem [MaxSubs];
  logic [LvlCntW-1:0]  cnt_rd_q;
  logic                mark_mem [MaxSubs];
  logic                mark_rd_q;
  row_t                row_rd_q [MaxLevels];
  logic                hit_pair;

  assign rd_addr     = iss_q[SubW-1:0];
  assign res_valid_o = (state_q == StateDone);
  assign res_o       = res_q;

  // one memory per constraint level, all levels of a slot read together
  for (genvar l = 0; l < MaxLevels; l++) begin : g_lvl
    row_t lvl_mem [MaxSubs];
    always_ff @(posedge clk_i) begin
      if (cs_we && pend_q[LvlW-1:0] == LvlW'(l)) begin
        lvl_mem[total_q[SubW-1:0]] <= '{attr: cmd_i.attribute, lo: cmd_i.lov,
                                         hi: cmd_i.hib};
      end
      row_rd_q[l] <= lvl_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) count_mem[total_q[SubW-1:0]] <= pend_q;
    cnt_rd_q <= count_mem[rd_addr];
    if (mk_we) mark_mem[mk_addr] <= mk_data;
    mark_rd_q <= mark_mem[rd_addr];
  end

  always_comb begin
    hit_pair = 1'b0;
    for (int l = 0; l < MaxLevels; l++) begin
      if (LvlCntW'(l) < cnt_rd_q && row_rd_q[l].attr == cmd_q.attribute &&
          (row_rd_q[l].lo > cmd_q.lov || row_rd_q[l].hi < cmd_q.lov)) begin
        hit_pair = 1'b1;
      end
    end
  end

  always_comb begin
    state_d   = state_q;
    total_d   = total_q;
    pend_d    = pend_q;
    pairs_d   = pairs_q;
    cursor_d  = cursor_q;
    iss_d     = iss_q;
    pv_d      = 1'b0;
    pa_d      = pa_q;
    reply_d   = reply_q;
    cmd_d     = cmd_q;
    res_d     = res_q;
    cmd_pop_o = 1'b0;
    cs_we     = 1'b0;
    cnt_we    = 1'b0;
    mk_we     = 1'b0;
    mk_addr   = pa_q;
    mk_data   = 1'b1;
    unique case (state_q)
      StateIdle: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          res_d     = '{status: StOk, handle: '0};
          state_d   = StateDone;
          unique case (cmd_i.op)
            OpAdd: begin
              if (total_q >= TotW'(MaxSubs)) begin
                res_d.status = StFull;
              end else if (pend_q >= LvlCntW'(MaxLevels)) begin
                res_d.status = StBadCount;
              end else begin
                cs_we  = 1'b1;
                pend_d = pend_q + 1'b1;
              end
            end
            OpCommit: begin
              if (total_q >= TotW'(MaxSubs)) begin
                res_d.status = StFull;
              end else if (pend_q == '0) begin
                res_d.status = StBadCount;
              end else begin
                cnt_we       = 1'b1;
                res_d.handle = HandleW'(total_q);
                pend_d       = '0;
                total_d      = total_q + 1'b1;
              end
            end
            OpBegin: begin
              pairs_d  = '0;
              cursor_d = '0;
              iss_d    = '0;
              reply_d  = 1'b1;
              state_d  = StateClear;
            end
            OpPair: begin
              if (pairs_q != '1) pairs_d = pairs_q + 1'b1;
              iss_d   = '0;
              state_d = StatePair;
            end
            OpRead: begin
              iss_d   = cursor_q;
              state_d = StateRead;
            end
            default: ;
          endcase
        end
      end
      StateClear: begin
        mk_we   = 1'b1;
        mk_addr = rd_addr;
        mk_data = 1'b0;
        if (iss_q == TotW'(MaxSubs - 1)) begin
          res_d   = '{status: StOk, handle: '0};
          state_d = reply_q ? StateDone : StateIdle;
        end else begin
          iss_d = iss_q + 1'b1;
        end
      end
      StatePair: begin
        mk_we = pv_q && hit_pair;
        if (iss_q >= total_q) begin
          state_d = StateDone;
        end else begin
          pv_d  = 1'b1;
          pa_d  = rd_addr;
          iss_d = iss_q + 1'b1;
        end
      end
      StateRead: begin
        if (pv_q && !mark_rd_q && cnt_rd_q <= LvlCntW'(pairs_q)) begin
          res_d    = '{status: StOk, handle: HandleW'(pa_q)};
          cursor_d = {1'b0, pa_q} + 1'b1;
          state_d  = StateDone;
        end else if (iss_q >= total_q) begin
          res_d    = '{status: StNoMatch, handle: '0};
          cursor_d = total_q;
          state_d  = StateDone;
        end else begin
          pv_d  = 1'b1;
          pa_d  = rd_addr;
          iss_d = iss_q + 1'b1;
        end
      end
      StateDone: begin
        if (res_ready_i) state_d = StateIdle;
      end
      default: state_d = StateIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StateClear;
      total_q  <= '0;
      pend_q   <= '0;
      pairs_q  <= '0;
      cursor_q <= '0;
      iss_q    <= '0;
      pv_q     <= 1'b0;
      reply_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      total_q  <= total_d;
      pend_q   <= pend_d;
      pairs_q  <= pairs_d;
      cursor_q <= cursor_d;
      iss_q    <= iss_d;
      pv_q     <= pv_d;
      reply_q  <= reply_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pa_q  <= pa_d;
    cmd_q <= cmd_d;
    res_q <= res_d;
  end

endmodule
